// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the multi-series event detector.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An antecedent that must be followed by a consequent at the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/msed_pkg.sv -----
// Package for the multi-series event detector: payload structs, configuration
// struct, phase encoding and register indexes. No dependencies.
`default_nettype none

package msed_pkg;

    localparam int STAMP_W    = 48;
    localparam int VALUE_W    = 32;
    localparam int NEED_W     = 5;
    localparam int GAP_W      = 47;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_INDEX_W = 3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_START_LEVEL        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_LEVEL          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_COUNT_NEEDED = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT_NEEDED  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TO_CLOSE       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BELOW_MODE         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_FIRST       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LAST        = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_IN    = 2'd1,
        PH_MAYBE = 2'd2
    } phase_t;

    typedef struct packed {
        logic                      req_type;
        logic signed [STAMP_W-1:0] stamp;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      is_missing;
        logic                      group_last;
    } in_item_t;

    typedef struct packed {
        logic signed [STAMP_W-1:0] event_begin;
        logic signed [STAMP_W-1:0] event_finish;
        logic                      closed_by_flush;
    } out_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] start_level;
        logic signed [VALUE_W-1:0] end_level;
        logic [NEED_W-1:0]         start_count_needed;
        logic [NEED_W-1:0]         keep_count_needed;
        logic [GAP_W-1:0]          gap_to_close;
        logic                      below_mode;
        logic signed [STAMP_W-1:0] window_first;
        logic signed [STAMP_W-1:0] window_last;
    } cfg_t;

    // Event tracking state that does not depend on the series count.
    typedef struct packed {
        phase_t                    phase;
        logic signed [STAMP_W-1:0] open_begin;
        logic signed [STAMP_W-1:0] open_finish;
    } ctl_state_t;

endpackage

`default_nettype wire

// ----- hdl/msed_step.sv -----
// Next-state logic of the event detector for one item: crossing counts,
// window check, gap test and the phase machine. Depends on msed_pkg.
`default_nettype none

module msed_step #(
    parameter int MAX_SERIES = 16,
    localparam int CW = $clog2(MAX_SERIES + 1)
) (
    input  msed_pkg::cfg_t       cfg,
    input  msed_pkg::ctl_state_t state,
    input  logic [CW-1:0]        start_hits,
    input  logic [CW-1:0]        keep_hits,
    input  msed_pkg::in_item_t   item,
    output msed_pkg::ctl_state_t state_next,
    output logic [CW-1:0]        start_hits_next,
    output logic [CW-1:0]        keep_hits_next,
    output logic                 emit,
    output msed_pkg::out_item_t  result
);
    import msed_pkg::*;

    localparam int NW = (CW > NEED_W) ? CW : NEED_W;

    logic                start_cross;
    logic                keep_cross;
    logic                count_en;
    logic [CW-1:0]       start_upd;
    logic [CW-1:0]       keep_upd;
    logic                start_ok;
    logic                keep_ok;
    logic                in_window;
    logic signed [STAMP_W:0] gap_diff;
    logic                gap_ok;
    logic                idle_rule;

    assign start_cross = cfg.below_mode
        ? ($signed(item.sample_value) < $signed(cfg.start_level))
        : ($signed(item.sample_value) > $signed(cfg.start_level));
    assign keep_cross = cfg.below_mode
        ? ($signed(item.sample_value) < $signed(cfg.end_level))
        : ($signed(item.sample_value) > $signed(cfg.end_level));
    assign count_en = !item.is_missing;

    // Counts saturate at the series count.
    assign start_upd = (count_en && start_cross && (start_hits < CW'(MAX_SERIES)))
        ? start_hits + CW'(1) : start_hits;
    assign keep_upd = (count_en && keep_cross && (keep_hits < CW'(MAX_SERIES)))
        ? keep_hits + CW'(1) : keep_hits;

    assign start_ok = NW'(start_upd) >= NW'(cfg.start_count_needed);
    assign keep_ok  = NW'(keep_upd) >= NW'(cfg.keep_count_needed);

    assign in_window = ($signed(item.stamp) >= $signed(cfg.window_first))
        && ($signed(item.stamp) <= $signed(cfg.window_last));

    // The difference is one bit wider so that it never wraps; a negative gap never closes.
    assign gap_diff = {item.stamp[STAMP_W-1], item.stamp}
        - {state.open_finish[STAMP_W-1], state.open_finish};
    assign gap_ok = gap_diff >= $signed({2'b00, cfg.gap_to_close});

    always_comb
    begin
        state_next                = state;
        start_hits_next           = start_hits;
        keep_hits_next            = keep_hits;
        emit                      = 1'b0;
        idle_rule                 = 1'b0;
        result.event_begin        = state.open_begin;
        result.event_finish       = state.open_finish;
        result.closed_by_flush    = 1'b0;

        if (item.req_type == REQ_FLUSH)
        begin
            start_hits_next        = '0;
            keep_hits_next         = '0;
            emit                   = (state.phase == PH_IN) || (state.phase == PH_MAYBE);
            result.closed_by_flush = 1'b1;
            state_next.phase       = PH_IDLE;
        end
        else
        begin
            start_hits_next = start_upd;
            keep_hits_next  = keep_upd;
            if (item.group_last)
            begin
                start_hits_next = '0;
                keep_hits_next  = '0;
                if (in_window)
                begin
                    unique case (state.phase)
                        PH_MAYBE:
                        begin
                            if (gap_ok)
                            begin
                                emit      = 1'b1;
                                idle_rule = 1'b1;
                            end
                            else if (keep_ok)
                            begin
                                state_next.open_finish = item.stamp;
                                state_next.phase       = PH_IN;
                            end
                        end
                        PH_IN:
                        begin
                            if (keep_ok)
                                state_next.open_finish = item.stamp;
                            else
                                state_next.phase = PH_MAYBE;
                        end
                        default:
                        begin
                            idle_rule = 1'b1;
                        end
                    endcase

                    // Idle behavior, also applied right after a gap closes an event.
                    if (idle_rule)
                    begin
                        state_next.phase = PH_IDLE;
                        if (start_ok)
                        begin
                            state_next.open_begin  = item.stamp;
                            state_next.open_finish = item.stamp;
                            state_next.phase       = keep_ok ? PH_IN : PH_MAYBE;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/multi_series_event_detector.sv -----
// Top level of the multi-series event detector: configuration registers,
// input and result registers, and the state registers. Depends on msed_pkg,
// msed_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Samples of up to MAX_SERIES series come in one per transaction, grouped by
// timestamp with the last sample of each group flagged; a flush transaction
// closes any open event. An accepted transaction is held in an input register
// and evaluated from there; its result is held in a result register. One
// transaction is taken every cycle while the result side is not stalled; the
// limit is the feedback loop through the count compare, the 49-bit gap
// subtract and the phase update. At most one result follows each transaction.
// Configuration writes take effect for items evaluated afterwards and should
// only be made while the block is idle. No initialization pass follows reset.
module multi_series_event_detector #(
    parameter int MAX_SERIES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [msed_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [msed_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  msed_pkg::in_item_t                    item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output msed_pkg::out_item_t                   result
);
    import msed_pkg::*;

    localparam int CW = $clog2(MAX_SERIES + 1);

    cfg_t          cfg_reg;
    in_item_t      s1_item_reg;
    logic          s1_valid_reg;
    ctl_state_t    state_reg;
    ctl_state_t    state_next;
    logic [CW-1:0] start_hits_reg;
    logic [CW-1:0] start_hits_next;
    logic [CW-1:0] keep_hits_reg;
    logic [CW-1:0] keep_hits_next;
    logic          res_valid_reg;
    out_item_t     res_reg;
    out_item_t     step_result;
    logic          step_emit;
    logic          advance;
    logic          fire;

    // The evaluation stage moves when the result register is free or being emptied.
    assign advance    = !res_valid_reg || !result_stall;
    assign fire       = s1_valid_reg && advance;
    assign item_stall = s1_valid_reg && !advance;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level        <= '0;
            cfg_reg.end_level          <= '0;
            cfg_reg.start_count_needed <= 5'd1;
            cfg_reg.keep_count_needed  <= 5'd1;
            cfg_reg.gap_to_close       <= 47'd1;
            cfg_reg.below_mode         <= 1'b0;
            cfg_reg.window_first       <= 48'sh8000_0000_0000;
            cfg_reg.window_last        <= 48'sh7FFF_FFFF_FFFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_LEVEL:        cfg_reg.start_level        <= cfg_wdata[VALUE_W-1:0];
                REG_END_LEVEL:          cfg_reg.end_level          <= cfg_wdata[VALUE_W-1:0];
                REG_START_COUNT_NEEDED: cfg_reg.start_count_needed <= cfg_wdata[NEED_W-1:0];
                REG_KEEP_COUNT_NEEDED:  cfg_reg.keep_count_needed  <= cfg_wdata[NEED_W-1:0];
                REG_GAP_TO_CLOSE:       cfg_reg.gap_to_close       <= cfg_wdata[GAP_W-1:0];
                REG_BELOW_MODE:         cfg_reg.below_mode         <= cfg_wdata[0];
                REG_WINDOW_FIRST:       cfg_reg.window_first       <= cfg_wdata[STAMP_W-1:0];
                REG_WINDOW_LAST:        cfg_reg.window_last        <= cfg_wdata[STAMP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!item_stall)
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            s1_item_reg <= item;
    end

    msed_step #(
        .MAX_SERIES(MAX_SERIES)
    ) u_step (
        .cfg             (cfg_reg),
        .state           (state_reg),
        .start_hits      (start_hits_reg),
        .keep_hits       (keep_hits_reg),
        .item            (s1_item_reg),
        .state_next      (state_next),
        .start_hits_next (start_hits_next),
        .keep_hits_next  (keep_hits_next),
        .emit            (step_emit),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.open_begin  <= '0;
            state_reg.open_finish <= '0;
            start_hits_reg        <= '0;
            keep_hits_reg         <= '0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            start_hits_reg <= start_hits_next;
            keep_hits_reg  <= keep_hits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= fire && step_emit;
    end

    always_ff @(posedge clk)
    begin
        if (fire && step_emit)
            res_reg <= step_result;
    end

    `ASSERT_NEXT(a_flush_clears, fire && (s1_item_reg.req_type == REQ_FLUSH),
        (state_reg.phase == PH_IDLE) && (start_hits_reg == '0) && (keep_hits_reg == '0),
        "flush did not return the detector to idle with cleared counts")
    `ASSERT_CLK(a_emit_needs_open_event,
        !(fire && step_emit) || (state_reg.phase == PH_IN) || (state_reg.phase == PH_MAYBE),
        "result produced while no event was open")
    `ASSERT_NEXT(a_emit_reaches_output, fire && step_emit, res_valid_reg,
        "emitted event did not reach the result register")

endmodule

`default_nettype wire
